// ===== src/cba_pkg.sv =====
// ----------------------------------------------------------------------------
// Chunked bump allocator package
// Field widths, fixed constants, the mode codes and the word types shared by
// the interfaces, the allocator and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package cba_pkg;

  // Field widths
  localparam int unsigned ModeW   = 2;
  localparam int unsigned ReqW    = 24;
  localparam int unsigned SizeW   = 25;
  localparam int unsigned OffsetW = 21;
  localparam int unsigned SlotW   = 8;

  // Pool geometry
  localparam int unsigned MaxChunks   = 256;
  localparam int unsigned HeaderBytes = 16;
  localparam int unsigned AlignBytes  = 8;
  localparam int unsigned AlignShift  = $clog2(AlignBytes);

  localparam logic [OffsetW-1:0] ChunkSizeReset = OffsetW'(4096);
  localparam logic [OffsetW-1:0] HeaderOffset   = OffsetW'(HeaderBytes);
  localparam logic [SizeW-1:0]   HeaderSize     = SizeW'(HeaderBytes);
  localparam logic [SizeW-1:0]   AlignRound     = SizeW'(AlignBytes - 1);
  localparam logic [SlotW:0]     SlotLimit      = (SlotW + 1)'(MaxChunks);

  // Request modes
  typedef enum logic [ModeW-1:0] {
    MODE_ALLOC      = 2'd0,
    MODE_REALLOC    = 2'd1,
    MODE_RESET_POOL = 2'd2
  } cba_mode_e;

  // Request word as held in the input register
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [ReqW-1:0]  req_size;
    logic             has_old;
    logic [ReqW-1:0]  old_size;
  } cba_req_t;

  // Result word as held in the output register
  typedef struct packed {
    logic [SlotW-1:0]   chunk_slot;
    logic [OffsetW-1:0] data_offset;
    logic [SizeW-1:0]   stored_size;
    logic               fresh_slot;
    logic               big_item;
    logic               kept_old;
    logic               overflow;
  } cba_res_t;

endpackage : cba_pkg

`default_nettype wire

// ===== src/cba_if.sv =====
// ----------------------------------------------------------------------------
// Chunked bump allocator channels
// Valid/ready channels for configuration writes, requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

// Configuration write channel: chunk size in bytes
interface cba_cfg_if import cba_pkg::*;;
  logic               valid;
  logic               ready;
  logic [OffsetW-1:0] chunk_size;

  modport source (output valid, output chunk_size, input ready);
  modport sink   (input valid, input chunk_size, output ready);
endinterface : cba_cfg_if

// Request channel
interface cba_req_if import cba_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ModeW-1:0] mode;
  logic [ReqW-1:0]  req_size;
  logic             has_old;
  logic [ReqW-1:0]  old_size;

  modport source (output valid, output mode, output req_size, output has_old,
                  output old_size, input ready);
  modport sink   (input valid, input mode, input req_size, input has_old,
                  input old_size, output ready);
endinterface : cba_req_if

// Result channel
interface cba_res_if import cba_pkg::*;;
  logic               valid;
  logic               ready;
  logic [SlotW-1:0]   chunk_slot;
  logic [OffsetW-1:0] data_offset;
  logic [SizeW-1:0]   stored_size;
  logic               fresh_slot;
  logic               big_item;
  logic               kept_old;
  logic               overflow;

  modport source (output valid, output chunk_slot, output data_offset,
                  output stored_size, output fresh_slot, output big_item,
                  output kept_old, output overflow, input ready);
  modport sink   (input valid, input chunk_slot, input data_offset,
                  input stored_size, input fresh_slot, input big_item,
                  input kept_old, input overflow, output ready);
endinterface : cba_res_if

`default_nettype wire

// ===== src/chunked_bump_allocator.sv =====
// ----------------------------------------------------------------------------
// Chunked bump allocator
// Places allocation requests into numbered chunk slots of an arena.
//
// Usage:
//   cfg_i  - chunk size write; always ready, write only while idle.
//   req_i  - request words (allocate, reallocate, reset pool).
//   res_o  - one result word per request, in request order.
// Timing: an accepted word waits in the input register, moves into the output
//   register when that register is free, and is then offered on res_o.
// Throughput: one word per cycle while res_o takes results. The pool state
//   (current slot, fill offset, highest slot) is updated in the same cycle
//   the result is registered, so the next word sees it without a gap.
// Reset: pool rewinds to slot 0, highest slot 0, chunk size 4096; both
//   register stages empty.
// Stall: a held result keeps the output register; one more word waits in
//   the input register, after which req_i.ready drops until res_o moves.
// ----------------------------------------------------------------------------
`default_nettype none

module chunked_bump_allocator import cba_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  cba_cfg_if.sink   cfg_i,
  cba_req_if.sink   req_i,
  cba_res_if.source res_o
);

  logic [OffsetW-1:0] chunk_size_q;
  logic               in_valid_q;
  cba_req_t           in_q;
  logic               out_valid_q;
  cba_res_t           out_q, res_d;
  logic [SlotW-1:0]   cur_slot_q, cur_slot_d;
  logic [OffsetW-1:0] fill_q, fill_d;
  logic [SlotW-1:0]   high_slot_q, high_slot_d;
  logic               advance;

  // Handshakes
  assign advance     = in_valid_q & (~out_valid_q | res_o.ready);
  assign req_i.ready = ~in_valid_q | advance;
  assign cfg_i.ready = 1'b1;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_size_q <= ChunkSizeReset;
    end else if (cfg_i.valid) begin
      chunk_size_q <= cfg_i.chunk_size;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q.mode     <= req_i.mode;
      in_q.req_size <= req_i.req_size;
      in_q.has_old  <= req_i.has_old;
      in_q.old_size <= req_i.old_size;
    end
  end

  // Placement logic
  logic [SizeW-1:0]   stored;
  logic [SizeW-1:0]   need;
  logic               is_big;
  logic [OffsetW-1:0] left;
  logic               fits;
  logic [SlotW:0]     slot_p1, slot_p2;
  logic               fresh;
  logic [OffsetW-1:0] at;
  logic               keep;

  always_comb begin
    stored  = ((SizeW'(in_q.req_size) + AlignRound) >> AlignShift) << AlignShift;
    need    = stored + HeaderSize;
    is_big  = need > SizeW'(chunk_size_q);
    left    = (fill_q > chunk_size_q) ? '0 : chunk_size_q - fill_q;
    fits    = SizeW'(left) >= need;
    slot_p1 = {1'b0, cur_slot_q} + (SlotW + 1)'(1);
    slot_p2 = {1'b0, cur_slot_q} + (SlotW + 1)'(2);
    fresh   = cur_slot_q >= high_slot_q;
    at      = fits ? fill_q : '0;
    keep    = in_q.has_old && (in_q.old_size >= in_q.req_size);

    res_d       = '0;
    cur_slot_d  = cur_slot_q;
    fill_d      = fill_q;
    high_slot_d = high_slot_q;

    unique case (cba_mode_e'(in_q.mode))
      MODE_ALLOC, MODE_REALLOC: begin
        if (cba_mode_e'(in_q.mode) == MODE_REALLOC && keep) begin
          // old item still large enough
          res_d.kept_old    = 1'b1;
          res_d.stored_size = SizeW'(in_q.old_size);
        end else if (is_big) begin
          // dedicated oversize slot, then a fresh normal chunk
          if (slot_p2 >= SlotLimit) begin
            res_d.overflow = 1'b1;
          end else begin
            res_d.chunk_slot  = slot_p1[SlotW-1:0];
            res_d.data_offset = HeaderOffset;
            res_d.stored_size = stored;
            res_d.fresh_slot  = fresh;
            res_d.big_item    = 1'b1;
            cur_slot_d        = slot_p2[SlotW-1:0];
            fill_d            = '0;
          end
        end else if (!fits && slot_p1 >= SlotLimit) begin
          res_d.overflow = 1'b1;
        end else begin
          // bump within the current chunk or open the next one
          res_d.chunk_slot  = fits ? cur_slot_q : slot_p1[SlotW-1:0];
          res_d.data_offset = at + HeaderOffset;
          res_d.stored_size = stored;
          res_d.fresh_slot  = ~fits & fresh;
          cur_slot_d        = fits ? cur_slot_q : slot_p1[SlotW-1:0];
          fill_d            = at + need[OffsetW-1:0];
        end
      end
      MODE_RESET_POOL: begin
        if (cur_slot_q > high_slot_q) begin
          high_slot_d = cur_slot_q;
        end
        cur_slot_d = '0;
        fill_d     = '0;
      end
      default: begin
        // unused mode: zero result, state untouched
      end
    endcase
  end

  // Pool state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_slot_q  <= '0;
      fill_q      <= '0;
      high_slot_q <= '0;
    end else if (advance) begin
      cur_slot_q  <= cur_slot_d;
      fill_q      <= fill_d;
      high_slot_q <= high_slot_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.chunk_slot  = out_q.chunk_slot;
  assign res_o.data_offset = out_q.data_offset;
  assign res_o.stored_size = out_q.stored_size;
  assign res_o.fresh_slot  = out_q.fresh_slot;
  assign res_o.big_item    = out_q.big_item;
  assign res_o.kept_old    = out_q.kept_old;
  assign res_o.overflow    = out_q.overflow;

endmodule : chunked_bump_allocator

`default_nettype wire

// ===== src/cba_checker.sv =====
// ----------------------------------------------------------------------------
// Chunked bump allocator checker
// Port-level assertions on the result channel, bound to the allocator.
// ----------------------------------------------------------------------------
`default_nettype none

module cba_checker import cba_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               res_valid_i,
  input logic               res_ready_i,
  input logic [SlotW-1:0]   chunk_slot_i,
  input logic [OffsetW-1:0] data_offset_i,
  input logic [SizeW-1:0]   stored_size_i,
  input logic               fresh_slot_i,
  input logic               big_item_i,
  input logic               kept_old_i,
  input logic               overflow_i
);

  // Held result word stays put
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i &&
      $stable({chunk_slot_i, data_offset_i, stored_size_i, fresh_slot_i,
               big_item_i, kept_old_i, overflow_i}))
    else $error("result word changed while stalled");

  // Refused request carries nothing else
  a_overflow_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && overflow_i |-> chunk_slot_i == '0 && data_offset_i == '0 &&
      stored_size_i == '0 && !fresh_slot_i && !big_item_i && !kept_old_i)
    else $error("overflow result with placement fields set");

  // Kept item makes no placement
  a_kept_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && kept_old_i |-> chunk_slot_i == '0 && data_offset_i == '0 &&
      !fresh_slot_i && !big_item_i && !overflow_i)
    else $error("kept result with placement fields set");

  // Oversize item sits just after its header in a slot above zero
  a_big_place: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && big_item_i |-> data_offset_i == HeaderOffset &&
      chunk_slot_i != '0 && stored_size_i[AlignShift-1:0] == '0)
    else $error("oversize item placed wrongly");

endmodule : cba_checker

bind chunked_bump_allocator cba_checker u_cba_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .chunk_slot_i  (res_o.chunk_slot),
  .data_offset_i (res_o.data_offset),
  .stored_size_i (res_o.stored_size),
  .fresh_slot_i  (res_o.fresh_slot),
  .big_item_i    (res_o.big_item),
  .kept_old_i    (res_o.kept_old),
  .overflow_i    (res_o.overflow)
);

`default_nettype wire
